>>> rtl/sorted_alarm_timer_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted alarm timer queue
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_ALARM_TIMER_QUEUE_ASSERT_SVH
`define SORTED_ALARM_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication
`define SATQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("satq check failed");

// next-cycle implication
`define SATQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("satq check failed");

`endif

>>> rtl/satq_pkg.sv
// ----------------------------------------------------------------------------
// satq_pkg
// Shared types and codes of the sorted alarm timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package satq_pkg;

  localparam int TIME_W      = 32;
  localparam int ID_W        = 8;
  localparam int FUNC_W      = 2;
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = 5;   // holds 0..MAX_RESULTS

  // request function codes (code 3 is ignored)
  localparam logic [FUNC_W-1:0] FUNC_TICK      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SLEEP_ABS = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SLEEP_DUR = 2'd2;

  typedef enum logic [1:0] {
    KIND_WAKE    = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REFUSED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_TICK     = 2'd1,
    ST_INS      = 2'd2,
    ST_INS_HEAD = 2'd3
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   owner;
  } entry_t;

  localparam int ENTRY_W = TIME_W + ID_W;

endpackage

`default_nettype wire

>>> rtl/sorted_alarm_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue
// Tick counter plus a deadline-sorted queue of sleep requests held in one RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every result shows
// on the out_ ports for exactly one cycle with out_valid high, the cycle after
// the cycle that decides it; nothing here can hold a result back, so the
// receiver must take it then. The queue lives in a circular buffer in a
// registered-read RAM (head pointer plus fill count). A tick bumps the time,
// reads the head at acceptance and then pops one due entry per cycle, so it
// keeps busy high until no due entry is left (at most 16 per tick); a wake
// is held back in a pending register to learn whether it is the last.
// A sleep request into an empty queue, a refused request (queue full) and
// func code 3 never raise busy. Any other sleep request walks the queue from
// the tail toward the head, one RAM read and one write per cycle, moving
// later-or-equal entries up one slot before the new entry is written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_alarm_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [satq_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [satq_pkg::TIME_W-1:0]    in_wake_value,
  input  wire logic [satq_pkg::ID_W-1:0]      in_requester_id,
  output logic                                out_valid,
  output logic [1:0]                          out_kind,
  output logic [satq_pkg::ID_W-1:0]           out_woken_id,
  output logic [satq_pkg::TIME_W-1:0]         out_current_time,
  output logic                                out_last
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = satq_pkg::TIME_W;
  localparam int IW    = satq_pkg::ID_W;
  localparam int NW    = satq_pkg::NRES_W;

  // logical slot -> physical RAM address (sum stays below twice the depth)
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // control state
  satq_pkg::state_t  state_r, state_nxt;
  logic [TW-1:0]     time_r, time_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [NW-1:0]     nrel_r, nrel_nxt;       // wakes released by this tick
  logic              pend_v_r, pend_v_nxt;   // a wake held for its last flag
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [IW-1:0]     pend_id_r, pend_id_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;         // logical slot under the insert scan
  satq_pkg::entry_t  new_r, new_nxt;         // entry being inserted
  satq_pkg::kind_t   out_kind_r, out_kind_nxt;
  logic [IW-1:0]     out_id_r, out_id_nxt;
  logic [TW-1:0]     out_time_r, out_time_nxt;
  logic              out_last_r, out_last_nxt;

  // RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  satq_pkg::entry_t  ram_wdata, ram_rdata;
  logic [satq_pkg::ENTRY_W-1:0] ram_rdata_raw;

  satq_ram #(
    .WIDTH (satq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = satq_pkg::entry_t'(ram_rdata_raw);

  // decode shared by both control blocks
  logic              accept;
  logic              is_tick, is_sleep;
  logic              q_full, q_empty;
  logic              due;        // head entry gets released on this tick
  logic              shift_up;   // scanned entry is equal or later than new one
  logic              scan_top;   // scan reached logical slot 0
  logic [TW:0]       dur_sum;
  logic [TW-1:0]     in_deadline;
  logic [CNT_W-1:0]  count_m1;

  assign busy      = (state_r != satq_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign is_tick   = (in_func == satq_pkg::FUNC_TICK);
  assign is_sleep  = (in_func == satq_pkg::FUNC_SLEEP_ABS) ||
                     (in_func == satq_pkg::FUNC_SLEEP_DUR);
  assign q_full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_empty   = (count_r == '0);
  assign count_m1  = count_r - 1'b1;
  assign due       = !q_empty && (nrel_r != NW'(satq_pkg::MAX_RESULTS)) &&
                     (ram_rdata.deadline <= time_r);
  assign shift_up  = (ram_rdata.deadline >= new_r.deadline);
  assign scan_top  = (idx_r == '0);

  // duration deadlines saturate at all ones
  assign dur_sum     = {1'b0, time_r} + {1'b0, in_wake_value};
  assign in_deadline = (in_func == satq_pkg::FUNC_SLEEP_ABS) ? in_wake_value :
                       (dur_sum[TW] ? {TW{1'b1}} : dur_sum[TW-1:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      satq_pkg::ST_IDLE: begin
        if (accept && is_tick) begin
          state_nxt = satq_pkg::ST_TICK;
        end else if (accept && is_sleep && !q_full && !q_empty) begin
          state_nxt = satq_pkg::ST_INS;
        end
      end
      satq_pkg::ST_TICK: begin
        if (!due) begin
          state_nxt = satq_pkg::ST_IDLE;
        end
      end
      satq_pkg::ST_INS: begin
        if (!shift_up) begin
          state_nxt = satq_pkg::ST_IDLE;
        end else if (scan_top) begin
          state_nxt = satq_pkg::ST_INS_HEAD;
        end
      end
      satq_pkg::ST_INS_HEAD: begin
        state_nxt = satq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = satq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath, RAM access and results
  always_comb begin
    time_nxt      = time_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    nrel_nxt      = nrel_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    idx_nxt       = idx_r;
    new_nxt       = new_r;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = new_r;
    ram_raddr     = head_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = satq_pkg::KIND_NONE;
    out_id_nxt    = '0;
    out_time_nxt  = time_r;
    out_last_nxt  = 1'b0;

    case (state_r)
      satq_pkg::ST_IDLE: begin
        if (accept && is_tick) begin
          // bump time, head read already issued at ram_raddr = head_r
          time_nxt   = time_r + 1'b1;
          nrel_nxt   = '0;
          pend_v_nxt = 1'b0;
        end else if (accept && is_sleep) begin
          new_nxt = '{deadline: in_deadline, owner: in_requester_id};
          if (q_full) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = satq_pkg::KIND_REFUSED;
            out_last_nxt  = 1'b1;
          end else if (q_empty) begin
            ram_we        = 1'b1;
            ram_waddr     = head_r;
            ram_wdata     = '{deadline: in_deadline, owner: in_requester_id};
            count_nxt     = count_r + 1'b1;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = satq_pkg::KIND_ACCEPT;
            out_last_nxt  = 1'b1;
          end else begin
            // start the scan at the tail
            idx_nxt   = count_m1[IDX_W-1:0];
            ram_raddr = wrap_add(head_r, count_m1[IDX_W-1:0]);
          end
        end
      end

      satq_pkg::ST_TICK: begin
        if (due) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = satq_pkg::KIND_WAKE;
            out_id_nxt    = pend_id_r;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = ram_rdata.owner;
          head_nxt    = wrap_add(head_r, IDX_W'(1));
          count_nxt   = count_r - 1'b1;
          nrel_nxt    = nrel_r + 1'b1;
          ram_raddr   = wrap_add(head_r, IDX_W'(1));
        end else begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (pend_v_r) begin
            out_kind_nxt = satq_pkg::KIND_WAKE;
            out_id_nxt   = pend_id_r;
          end else begin
            out_kind_nxt = satq_pkg::KIND_NONE;
          end
          pend_v_nxt = 1'b0;
        end
      end

      satq_pkg::ST_INS: begin
        // the write goes one slot above the read, never to a slot still to be read
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head_r, idx_r + 1'b1);
        if (shift_up) begin
          ram_wdata = ram_rdata;
          if (!scan_top) begin
            idx_nxt   = idx_r - 1'b1;
            ram_raddr = wrap_add(head_r, idx_r - 1'b1);
          end
        end else begin
          ram_wdata     = new_r;
          count_nxt     = count_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = satq_pkg::KIND_ACCEPT;
          out_last_nxt  = 1'b1;
        end
      end

      satq_pkg::ST_INS_HEAD: begin
        ram_we        = 1'b1;
        ram_waddr     = head_r;
        ram_wdata     = new_r;
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = satq_pkg::KIND_ACCEPT;
        out_last_nxt  = 1'b1;
      end

      default: begin
        pend_v_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= satq_pkg::ST_IDLE;
      time_r      <= '0;
      head_r      <= '0;
      count_r     <= '0;
      nrel_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      nrel_r      <= nrel_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    idx_r      <= idx_nxt;
    new_r      <= new_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_time_r <= out_time_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_woken_id     = out_id_r;
  assign out_current_time = out_time_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

>>> rtl/satq_ram.sv
// ----------------------------------------------------------------------------
// satq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module satq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/satq_checker.sv
// ----------------------------------------------------------------------------
// satq_checker
// Port-level checks of the sorted alarm timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_alarm_timer_queue_assert.svh"

module satq_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [satq_pkg::FUNC_W-1:0] in_func,
  input wire logic                        out_valid,
  input wire logic [1:0]                  out_kind,
  input wire logic [satq_pkg::ID_W-1:0]   out_woken_id,
  input wire logic                        out_last
);

  // only wakes carry an id
  `SATQ_ASSERT_NOW(a_id_zero, out_valid && (out_kind != satq_pkg::KIND_WAKE), out_woken_id == '0)

  // non-wake results always close their request
  `SATQ_ASSERT_NOW(a_single_last, out_valid && (out_kind != satq_pkg::KIND_WAKE), out_last)

  // a tick always raises busy
  `SATQ_ASSERT_NEXT(a_tick_busy, start && !busy && (in_func == satq_pkg::FUNC_TICK), busy)

  // wakes of one tick come out back to back until the last one
  `SATQ_ASSERT_NEXT(a_wake_burst, out_valid && !out_last, out_valid && (out_kind == satq_pkg::KIND_WAKE))

endmodule

bind sorted_alarm_timer_queue satq_checker u_satq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_func      (in_func),
  .out_valid    (out_valid),
  .out_kind     (out_kind),
  .out_woken_id (out_woken_id),
  .out_last     (out_last)
);

`default_nettype wire

>>> verif/tb_sorted_alarm_timer_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_alarm_timer_queue
// Self-checking bench for the deadline-sorted alarm timer queue. A short
// table of directed requests (extremes, saturation, past deadlines, full
// queue, mass release) runs first. Random phases with different sender
// idle rates follow. Every result is checked field by field against the
// typed row's reply or a behavioral model of the counter and sorted list.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_alarm_timer_queue;

  localparam int DEPTH       = 16;
  localparam int FUNC_W      = satq_pkg::FUNC_W;
  localparam int ID_W        = satq_pkg::ID_W;
  localparam int TIME_W      = satq_pkg::TIME_W;
  localparam int MAX_RESULTS = satq_pkg::MAX_RESULTS;
  // func code 3 is accepted but ignored by the block
  localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;

  // one result as seen on the out_ ports
  typedef struct packed {
    satq_pkg::kind_t   kind;
    logic [ID_W-1:0]   woken;
    logic [TIME_W-1:0] ctime;
    logic              last;
  } reply_t;

  // one row of the directed table; fixed is used only when typed is set
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] value;
    logic [ID_W-1:0]   id;
    bit                typed;
    reply_t            fixed;
  } directed_row_t;

  localparam reply_t NO_FIXED    = '{satq_pkg::KIND_WAKE, 8'h00, 32'd0, 1'b0};
  localparam reply_t NONE_AT1    = '{satq_pkg::KIND_NONE, 8'h00, 32'd1, 1'b1};
  localparam reply_t NONE_AT3    = '{satq_pkg::KIND_NONE, 8'h00, 32'd3, 1'b1};
  localparam reply_t NONE_AT4    = '{satq_pkg::KIND_NONE, 8'h00, 32'd4, 1'b1};
  localparam reply_t ACCEPT_AT1  = '{satq_pkg::KIND_ACCEPT, 8'h00, 32'd1, 1'b1};
  localparam reply_t ACCEPT_AT2  = '{satq_pkg::KIND_ACCEPT, 8'h00, 32'd2, 1'b1};
  localparam reply_t REFUSED_AT2 = '{satq_pkg::KIND_REFUSED, 8'h00, 32'd2, 1'b1};

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] in_func;
  logic [TIME_W-1:0] in_wake_value;
  logic [ID_W-1:0]   in_requester_id;
  logic              out_valid;
  logic [1:0]        out_kind;
  logic [ID_W-1:0]   out_woken_id;
  logic [TIME_W-1:0] out_current_time;
  logic              out_last;

  sorted_alarm_timer_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_wake_value   (in_wake_value),
    .in_requester_id (in_requester_id),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_woken_id    (out_woken_id),
    .out_current_time(out_current_time),
    .out_last        (out_last)
  );

  // --------------------------------------------------------------------------
  // Model state: tick counter plus the sleep list, sorted by deadline
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] model_time;
  logic [TIME_W-1:0] timer_deadlines[$];
  logic [ID_W-1:0]   timer_owners[$];
  reply_t            due_replies[$];   // results still owed by the block
  int                mismatches;

  // set by the driver alongside the request ports, read by the monitor
  bit                cur_typed;
  reply_t            cur_fixed;

  // Applies one request to the model. With keep clear the state still moves
  // but the results are dropped (the directed table supplies them instead).
  function automatic void advance_alarm_model(logic [FUNC_W-1:0] func,
                                              logic [TIME_W-1:0] value,
                                              logic [ID_W-1:0] id, bit keep);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] deadline;
    int                n;
    int                pos;
    reply_t            r;
    case (func)
      satq_pkg::FUNC_TICK: begin
        model_time = model_time + 1'b1;
        n = 0;
        // release from the head while due, capped per tick
        while (n < timer_deadlines.size() && n < MAX_RESULTS &&
               timer_deadlines[n] <= model_time)
          n++;
        if (n == 0) begin
          r = '{satq_pkg::KIND_NONE, 8'h00, model_time, 1'b1};
          if (keep) due_replies.push_back(r);
        end
        for (int i = 0; i < n; i++) begin
          r = '{satq_pkg::KIND_WAKE, timer_owners[i], model_time, (i == n - 1)};
          if (keep) due_replies.push_back(r);
        end
        repeat (n) begin
          void'(timer_deadlines.pop_front());
          void'(timer_owners.pop_front());
        end
      end
      satq_pkg::FUNC_SLEEP_ABS, satq_pkg::FUNC_SLEEP_DUR: begin
        if (func == satq_pkg::FUNC_SLEEP_DUR) begin
          // saturate on overflow of time + duration
          sum = {1'b0, model_time} + {1'b0, value};
          deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end else begin
          deadline = value;
        end
        if (timer_deadlines.size() >= DEPTH) begin
          r = '{satq_pkg::KIND_REFUSED, 8'h00, model_time, 1'b1};
        end else begin
          // goes ahead of any equal or later deadline
          pos = 0;
          while (pos < timer_deadlines.size() && timer_deadlines[pos] < deadline)
            pos++;
          timer_deadlines.insert(pos, deadline);
          timer_owners.insert(pos, id);
          r = '{satq_pkg::KIND_ACCEPT, 8'h00, model_time, 1'b1};
        end
        if (keep) due_replies.push_back(r);
      end
      default: ;  // ignored code: no state change, no result
    endcase
  endfunction

  // Random wake value. Mostly near the current time so ticks release them;
  // huge values never come due, so they are only issued while the list has
  // room left, to keep the queue from clogging for good.
  function automatic logic [TIME_W-1:0] pick_wake_value(logic [FUNC_W-1:0] func);
    int c;
    c = $urandom_range(99);
    if (timer_deadlines.size() < 8 && c < 3) return $urandom();
    if (func == satq_pkg::FUNC_SLEEP_DUR) begin
      if (timer_deadlines.size() < 8 && c < 6) return 32'hFFFF_FFFF - $urandom_range(0, 300);
      return $urandom_range(0, 5);
    end
    if (c < 20) return model_time - ((model_time < 6) ? model_time : $urandom_range(0, 6));
    return model_time + $urandom_range(0, 5);
  endfunction

  task automatic compare_field(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: samples at the rising edge. Results go out first, then a
  // request accepted at the same edge is applied to the model; its results
  // can only show up at a later edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (due_replies.size() == 0) begin
          $error("result with nothing expected: kind %0d id 0x%0h time 0x%0h",
                 out_kind, out_woken_id, out_current_time);
          mismatches++;
        end else begin
          compare_field("kind", due_replies[0].kind, out_kind);
          compare_field("woken_id", due_replies[0].woken, out_woken_id);
          compare_field("current_time", due_replies[0].ctime, out_current_time);
          compare_field("last", due_replies[0].last, out_last);
          void'(due_replies.pop_front());
        end
      end
      if (start && !busy) begin
        advance_alarm_model(in_func, in_wake_value, in_requester_id, !cur_typed);
        if (cur_typed) due_replies.push_back(cur_fixed);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: ports change at the falling edge. start stays high from one
  // request to the next unless an idle gap is drawn, so start is never
  // dropped and raised within one step.
  // --------------------------------------------------------------------------
  task automatic issue_request(logic [FUNC_W-1:0] func, logic [TIME_W-1:0] value,
                               logic [ID_W-1:0] id, bit typed, reply_t fixed,
                               int unsigned idle_pct);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 50) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func         <= func;
    in_wake_value   <= value;
    in_requester_id <= id;
    cur_typed        = typed;
    cur_fixed        = fixed;
    start           <= 1'b1;
    // wait for the handshake edge
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    directed_row_t     directed_rows[25];
    int unsigned       idle_pct[4];
    int                sent;
    int                r;
    int                n;
    int                drain;
    logic [FUNC_W-1:0] f;
    logic [TIME_W-1:0] v;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = satq_pkg::FUNC_TICK;
    in_wake_value   = '0;
    in_requester_id = '0;
    cur_typed       = 1'b0;
    cur_fixed       = NO_FIXED;
    model_time      = '0;
    mismatches      = 0;
    idle_pct        = '{0, 78, 0, 29};

    // Directed table. Time starts at zero with an empty list.
    directed_rows = '{
      // tick on an empty queue: nothing due
      '{satq_pkg::FUNC_TICK,      32'h0000_0000, 8'h00, 1'b1, NONE_AT1},
      // largest absolute deadline, largest id
      '{satq_pkg::FUNC_SLEEP_ABS, 32'hFFFF_FFFF, 8'hFF, 1'b1, ACCEPT_AT1},
      // duration overflow saturates; ties with the entry above, goes first
      '{satq_pkg::FUNC_SLEEP_DUR, 32'hFFFF_FFFF, 8'h01, 1'b1, ACCEPT_AT1},
      // deadline already past
      '{satq_pkg::FUNC_SLEEP_ABS, 32'h0000_0000, 8'hAA, 1'b1, ACCEPT_AT1},
      // zero duration: due at the current time
      '{satq_pkg::FUNC_SLEEP_DUR, 32'h0000_0000, 8'h55, 1'b1, ACCEPT_AT1},
      // releases the past and the zero-duration entries
      '{satq_pkg::FUNC_TICK,      32'hFFFF_FFFF, 8'hFF, 1'b0, NO_FIXED},
      // unused code: no result
      '{FUNC_IGNORED,             32'h5A5A_5A5A, 8'hFF, 1'b0, NO_FIXED},
      // fill to the depth, all due at time 5 (abs 5 or now + 3)
      '{satq_pkg::FUNC_SLEEP_ABS, 32'd5, 8'h00, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_DUR, 32'd3, 8'h10, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_ABS, 32'd5, 8'h21, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_DUR, 32'd3, 8'h32, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_ABS, 32'd5, 8'h43, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_DUR, 32'd3, 8'h54, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_ABS, 32'd5, 8'h65, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_DUR, 32'd3, 8'h76, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_ABS, 32'd5, 8'h87, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_DUR, 32'd3, 8'h98, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_ABS, 32'd5, 8'hA9, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_DUR, 32'd3, 8'hBA, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_ABS, 32'd5, 8'hCB, 1'b1, ACCEPT_AT2},
      '{satq_pkg::FUNC_SLEEP_DUR, 32'd3, 8'hDC, 1'b1, ACCEPT_AT2},
      // queue full: refused, state kept
      '{satq_pkg::FUNC_SLEEP_ABS, 32'd7, 8'hEE, 1'b1, REFUSED_AT2},
      '{satq_pkg::FUNC_TICK,      32'h0000_0000, 8'h00, 1'b1, NONE_AT3},
      '{satq_pkg::FUNC_TICK,      32'h0000_0000, 8'h00, 1'b1, NONE_AT4},
      // many due at once: fourteen wakes on one tick
      '{satq_pkg::FUNC_TICK,      32'h0000_0000, 8'h00, 1'b0, NO_FIXED}
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].func, directed_rows[i].value, directed_rows[i].id,
                    directed_rows[i].typed, directed_rows[i].fixed, 0);

    // Random phases. Mostly ticks and near-term sleeps so releases keep
    // happening, plus bursts that push the queue to full, and a little noise
    // on the ignored code (not counted).
    for (int phase = 0; phase < 4; phase++) begin
      sent = 0;
      while (sent < 90) begin
        r = $urandom_range(99);
        if (r < 5) begin
          n = $urandom_range(6, 18);
          repeat (n) begin
            f = $urandom_range(1) ? satq_pkg::FUNC_SLEEP_ABS : satq_pkg::FUNC_SLEEP_DUR;
            issue_request(f, pick_wake_value(f), 8'($urandom()), 1'b0, NO_FIXED,
                          idle_pct[phase]);
          end
          sent += n;
        end else begin
          if (r < 45)      f = satq_pkg::FUNC_TICK;
          else if (r < 70) f = satq_pkg::FUNC_SLEEP_ABS;
          else if (r < 95) f = satq_pkg::FUNC_SLEEP_DUR;
          else             f = FUNC_IGNORED;
          v = (f == satq_pkg::FUNC_SLEEP_ABS || f == satq_pkg::FUNC_SLEEP_DUR) ?
              pick_wake_value(f) : $urandom();
          issue_request(f, v, 8'($urandom()), 1'b0, NO_FIXED, idle_pct[phase]);
          if (f != FUNC_IGNORED) sent++;
        end
      end
    end

    start <= 1'b0;

    // drain what is still owed, then allow for a full tick's worth of output
    drain = 0;
    while (due_replies.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (due_replies.size() != 0) begin
      $error("%0d expected results never arrived", due_replies.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("[sorted_alarm_timer_queue] OK");
    end else begin
      $display("[sorted_alarm_timer_queue] ERROR");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin
    #(12 * 400000);
    $display("[sorted_alarm_timer_queue] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
